>>> design/kes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_pkg
// Types and constants shared by the kruskal edge selector modules.
// ----------------------------------------------------------------------------
package kes_pkg;

  // operation codes
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_ACCEPTED   = 2'd0;
  localparam logic [1:0] STATUS_REJECTED   = 2'd1;
  localparam logic [1:0] STATUS_RANGE      = 2'd2;
  localparam logic [1:0] STATUS_CLEAR_DONE = 2'd3;

  // configuration register map
  localparam int         CFG_ADDR_W     = 3;
  localparam logic       REG_NODE_COUNT = 1'b0;
  localparam logic [8:0] NODE_COUNT_RST = 9'd511;

  localparam int          RANK_W    = 4;
  localparam logic [3:0]  RANK_MAX  = 4'd15;
  localparam logic [8:0]  COUNT_MAX = 9'd511;
  localparam logic signed [47:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] TOTAL_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic              operation;
    logic [8:0]        endpoint_a;
    logic [8:0]        endpoint_b;
    logic signed [31:0] edge_weight;
  } edge_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [47:0] total_weight;
    logic [8:0]         accepted_count;
  } result_item_t;

  typedef struct packed {
    logic clear;
    logic add;
  } totals_ctrl_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FIND,
    ST_COMPRESS,
    ST_START_B,
    ST_DECIDE,
    ST_BUMP,
    ST_REPORT
  } state_t;

endpackage

>>> design/kes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/kes_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_cfg
// APB register slice holding the node_count register.
// ----------------------------------------------------------------------------
module kes_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kes_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [8:0]                     node_count
);
  import kes_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (wr_en) begin
      unique case (paddr[CFG_ADDR_W-1])
        REG_NODE_COUNT: node_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[CFG_ADDR_W-1])
      REG_NODE_COUNT: prdata = {23'd0, node_count};
      default: prdata = '0;
    endcase
  end

endmodule

>>> design/kes_totals.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_totals
// Saturating weight accumulator and accepted-edge counter.
// ----------------------------------------------------------------------------
module kes_totals (
  input  logic                  clk,
  input  logic                  rst,
  input  kes_pkg::totals_ctrl_t ctrl,
  input  logic signed [31:0]    weight,
  output logic signed [47:0]    total_weight,
  output logic [8:0]            accepted_count
);
  import kes_pkg::*;

  logic signed [48:0] sum;
  logic signed [47:0] sum_sat;

  assign sum = {total_weight[47], total_weight} + {{17{weight[31]}}, weight};

  always_comb begin
    sum_sat = sum[47:0];
    // top two bits disagree on overflow
    if (!sum[48] && sum[47]) begin
      sum_sat = TOTAL_MAX;
    end else if (sum[48] && !sum[47]) begin
      sum_sat = TOTAL_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      total_weight   <= '0;
      accepted_count <= '0;
    end else if (ctrl.add) begin
      total_weight <= sum_sat;
      if (accepted_count != COUNT_MAX) begin
        accepted_count <= accepted_count + 9'd1;
      end
    end
  end

endmodule

>>> design/kruskal_edge_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_edge_selector
// Union-find edge acceptor for Kruskal's minimum spanning tree. Parent and
// rank of every node live in one table memory; a sequencer walks root chains,
// compresses paths and unites trees by rank.
//
//   channel  direction  handshake              payload
//   edge     in         edge_valid/edge_stall  edge_item   (edge_item_t)
//   result   out        result_valid/stall     result_item (result_item_t)
//   apb      in/out     psel/penable/pready    node_count register at 0x0
//
// an edge item walks from each endpoint to its root, one hop per cycle on
// the table read port, then compresses that path, plus a rank bump step when
// ranks tie. an out-of-range edge goes straight to its report step. a clear
// item writes entries 0 to min(node_count, NODES-1), one entry per cycle.
// after reset a clearing pass writes all NODES entries before the first item
// is taken. a stalled result holds the sequencer in its report step; the next
// item is taken as soon as the result register is loaded.
// ----------------------------------------------------------------------------
module kruskal_edge_selector #(
  parameter int NODES = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           edge_valid,
  output logic                           edge_stall,
  input  kes_pkg::edge_item_t            edge_item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output kes_pkg::result_item_t          result_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kes_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import kes_pkg::*;

  localparam int            AW        = $clog2(NODES);
  localparam int            EW        = AW + RANK_W;
  localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);

  state_t state, state_next;

  logic [8:0]         node_count;
  logic signed [47:0] total_weight;
  logic [8:0]         accepted_count;
  totals_ctrl_t       tot_ctrl;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  logic [AW-1:0]     sweep_idx;
  logic [AW-1:0]     sweep_last;
  logic              clear_pending;
  logic [AW-1:0]     a_idx;
  logic [AW-1:0]     b_idx;
  logic [AW-1:0]     cur;
  logic              walk_b;
  logic [AW-1:0]     root_a;
  logic [AW-1:0]     root_b;
  logic [RANK_W-1:0] rank_a;
  logic [RANK_W-1:0] rank_b;
  logic signed [31:0] weight;
  logic [1:0]        status;
  logic              load_result;

  logic [AW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic [AW-1:0]     walk_start;
  logic [AW-1:0]     walk_root;
  logic [RANK_W-1:0] rank_bump;
  logic              out_of_range;
  logic [AW-1:0]     clear_last;

  kes_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  kes_totals u_totals (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (tot_ctrl),
    .weight         (weight),
    .total_weight   (total_weight),
    .accepted_count (accepted_count)
  );

  // entry layout: {rank, parent}
  kes_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_parent  = ram_rdata[AW-1:0];
  assign rd_rank    = ram_rdata[EW-1:AW];
  assign walk_start = walk_b ? b_idx : a_idx;
  assign walk_root  = walk_b ? root_b : root_a;
  assign rank_bump  = (rank_a == RANK_MAX) ? rank_a : rank_a + 1'b1;

  assign out_of_range = (edge_item.endpoint_a > node_count) ||
                        (edge_item.endpoint_b > node_count) ||
                        (int'(edge_item.endpoint_a) >= NODES) ||
                        (int'(edge_item.endpoint_b) >= NODES);

  assign clear_last = (int'(node_count) > NODES - 1) ? LAST_NODE : AW'(node_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    edge_stall  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = cur;
    ram_wdata   = '0;
    ram_raddr   = cur;
    tot_ctrl    = '0;
    load_result = 1'b0;
    unique case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_idx;
        ram_wdata = {RANK_W'(0), sweep_idx};
        if (sweep_idx == sweep_last) begin
          state_next = clear_pending ? ST_REPORT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        edge_stall = 1'b0;
        ram_raddr  = AW'(edge_item.endpoint_a);
        if (edge_valid) begin
          if (edge_item.operation == OP_CLEAR) begin
            tot_ctrl.clear = 1'b1;
            state_next     = ST_SWEEP;
          end else if (out_of_range) begin
            state_next = ST_REPORT;
          end else begin
            state_next = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        if (rd_parent == cur) begin
          if (cur != walk_start) begin
            ram_raddr  = walk_start;
            state_next = ST_COMPRESS;
          end else begin
            state_next = walk_b ? ST_DECIDE : ST_START_B;
          end
        end else begin
          ram_raddr = rd_parent;
        end
      end
      ST_COMPRESS: begin
        // point this node at the root, then follow its old parent
        ram_we    = 1'b1;
        ram_waddr = cur;
        ram_wdata = {rd_rank, walk_root};
        if (rd_parent == walk_root) begin
          state_next = walk_b ? ST_DECIDE : ST_START_B;
        end else begin
          ram_raddr = rd_parent;
        end
      end
      ST_START_B: begin
        ram_raddr  = b_idx;
        state_next = ST_FIND;
      end
      ST_DECIDE: begin
        if (root_a == root_b) begin
          state_next = ST_REPORT;
        end else begin
          ram_we       = 1'b1;
          tot_ctrl.add = 1'b1;
          if (rank_a < rank_b) begin
            ram_waddr = root_a;
            ram_wdata = {rank_a, root_b};
          end else begin
            ram_waddr = root_b;
            ram_wdata = {rank_b, root_a};
          end
          state_next = (rank_a == rank_b) ? ST_BUMP : ST_REPORT;
        end
      end
      ST_BUMP: begin
        ram_we     = 1'b1;
        ram_waddr  = root_a;
        ram_wdata  = {rank_bump, root_a};
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx     <= '0;
      sweep_last    <= LAST_NODE;
      clear_pending <= 1'b0;
      walk_b        <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_SWEEP: sweep_idx <= sweep_idx + 1'b1;
        ST_IDLE: begin
          if (edge_valid) begin
            sweep_idx     <= '0;
            sweep_last    <= clear_last;
            clear_pending <= (edge_item.operation == OP_CLEAR);
            walk_b        <= 1'b0;
          end
        end
        ST_START_B: walk_b <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (edge_valid) begin
          a_idx  <= AW'(edge_item.endpoint_a);
          b_idx  <= AW'(edge_item.endpoint_b);
          cur    <= AW'(edge_item.endpoint_a);
          weight <= edge_item.edge_weight;
          if (edge_item.operation == OP_CLEAR) begin
            status <= STATUS_CLEAR_DONE;
          end else if (out_of_range) begin
            status <= STATUS_RANGE;
          end else begin
            status <= STATUS_ACCEPTED;
          end
        end
      end
      ST_FIND: begin
        if (rd_parent == cur) begin
          if (walk_b) begin
            root_b <= cur;
            rank_b <= rd_rank;
          end else begin
            root_a <= cur;
            rank_a <= rd_rank;
          end
          cur <= walk_start;
        end else begin
          cur <= rd_parent;
        end
      end
      ST_COMPRESS: cur <= rd_parent;
      ST_START_B:  cur <= b_idx;
      ST_DECIDE: begin
        status <= (root_a == root_b) ? STATUS_REJECTED : STATUS_ACCEPTED;
      end
      default: ;
    endcase
    if (load_result) begin
      result_item.status         <= status;
      result_item.total_weight   <= total_weight;
      result_item.accepted_count <= accepted_count;
    end
  end

  // compression never redirects the root itself
  a_compress_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPRESS) |-> (ram_waddr != walk_root))
    else $error("path compression wrote the root entry");

  // a union only ever rewrites one of the two roots
  a_union_on_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && ram_we) |-> (ram_waddr == root_a || ram_waddr == root_b))
    else $error("union wrote a non-root entry");

  // a waiting result is not overwritten
  a_report_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && result_valid && result_stall) |=> (state == ST_REPORT))
    else $error("result register reloaded while stalled");

  // the edge count moves only on a union or a clear
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && accepted_count != $past(accepted_count)) |->
      ($past(tot_ctrl.add) || $past(tot_ctrl.clear)))
    else $error("accepted count changed without a union or clear");

endmodule
